FILE: hw/rtl/sha384_pkg.sv
// Shared constants, types and helper functions of the SHA-384 hash engine.
`default_nettype none
package sha384_pkg;

  localparam int unsigned WordW      = 64;
  localparam int unsigned BlockWords = 16;
  localparam int unsigned Rounds     = 80;
  localparam int unsigned DigestWords = 6;
  localparam logic [2:0]  DigestLastIdx = 3'(DigestWords - 1);
  localparam logic [6:0]  LastRound  = 7'(Rounds - 1);
  localparam logic [6:0]  PadStop    = 7'd112;
  localparam logic [7:0]  PadByte    = 8'h80;

  localparam logic [63:0] InitValue [8] = '{
    64'hcbbb9d5dc1059ed8, 64'h629a292a367cd507, 64'h9159015a3070dd17, 64'h152fecd8f70e5939,
    64'h67332667ffc00b31, 64'h8eb44a8768581511, 64'hdb0c2e0d64f98fa7, 64'h47b5481dbefa4fa4};

  localparam logic [63:0] RoundConst [80] = '{
    64'h428A2F98D728AE22, 64'h7137449123EF65CD, 64'hB5C0FBCFEC4D3B2F, 64'hE9B5DBA58189DBBC,
    64'h3956C25BF348B538, 64'h59F111F1B605D019, 64'h923F82A4AF194F9B, 64'hAB1C5ED5DA6D8118,
    64'hD807AA98A3030242, 64'h12835B0145706FBE, 64'h243185BE4EE4B28C, 64'h550C7DC3D5FFB4E2,
    64'h72BE5D74F27B896F, 64'h80DEB1FE3B1696B1, 64'h9BDC06A725C71235, 64'hC19BF174CF692694,
    64'hE49B69C19EF14AD2, 64'hEFBE4786384F25E3, 64'h0FC19DC68B8CD5B5, 64'h240CA1CC77AC9C65,
    64'h2DE92C6F592B0275, 64'h4A7484AA6EA6E483, 64'h5CB0A9DCBD41FBD4, 64'h76F988DA831153B5,
    64'h983E5152EE66DFAB, 64'hA831C66D2DB43210, 64'hB00327C898FB213F, 64'hBF597FC7BEEF0EE4,
    64'hC6E00BF33DA88FC2, 64'hD5A79147930AA725, 64'h06CA6351E003826F, 64'h142929670A0E6E70,
    64'h27B70A8546D22FFC, 64'h2E1B21385C26C926, 64'h4D2C6DFC5AC42AED, 64'h53380D139D95B3DF,
    64'h650A73548BAF63DE, 64'h766A0ABB3C77B2A8, 64'h81C2C92E47EDAEE6, 64'h92722C851482353B,
    64'hA2BFE8A14CF10364, 64'hA81A664BBC423001, 64'hC24B8B70D0F89791, 64'hC76C51A30654BE30,
    64'hD192E819D6EF5218, 64'hD69906245565A910, 64'hF40E35855771202A, 64'h106AA07032BBD1B8,
    64'h19A4C116B8D2D0C8, 64'h1E376C085141AB53, 64'h2748774CDF8EEB99, 64'h34B0BCB5E19B48A8,
    64'h391C0CB3C5C95A63, 64'h4ED8AA4AE3418ACB, 64'h5B9CCA4F7763E373, 64'h682E6FF3D6B2B8A3,
    64'h748F82EE5DEFB2FC, 64'h78A5636F43172F60, 64'h84C87814A1F0AB72, 64'h8CC702081A6439EC,
    64'h90BEFFFA23631E28, 64'hA4506CEBDE82BDE9, 64'hBEF9A3F7B2C67915, 64'hC67178F2E372532B,
    64'hCA273ECEEA26619C, 64'hD186B8C721C0C207, 64'hEADA7DD6CDE0EB1E, 64'hF57D4F7FEE6ED178,
    64'h06F067AA72176FBA, 64'h0A637DC5A2C898A6, 64'h113F9804BEF90DAE, 64'h1B710B35131C471B,
    64'h28DB77F523047D84, 64'h32CAAB7B40C72493, 64'h3C9EBE0A15C9BEBC, 64'h431D67C49C100D4C,
    64'h4CC5D4BECB3E42B6, 64'h597F299CFC657E2A, 64'h5FCB6FAB3AD6FAEC, 64'h6C44198C4A475817};

  // Control from the sequencer to the compression core.
  typedef struct packed {
    logic start;
    logic init;
  } core_ctl_t;

  // Status from the compression core.
  typedef struct packed {
    logic busy;
    logic done;
  } core_stat_t;

  function automatic logic [63:0] rotr(input logic [63:0] x, input int unsigned n);
    rotr = (x >> n) | (x << (64 - n));
  endfunction

endpackage
`default_nettype wire

FILE: hw/rtl/sha384_if.sv
// Handshake interfaces for the message word and digest word channels.
`default_nettype none
interface sha384_msg_if;
  logic        valid;
  logic        ready;
  logic [63:0] message_word;
  logic [3:0]  valid_bytes;
  logic        last_word;
  modport source (output valid, message_word, valid_bytes, last_word, input ready);
  modport sink (input valid, message_word, valid_bytes, last_word, output ready);
endinterface

interface sha384_dig_if;
  logic        valid;
  logic        ready;
  logic [63:0] digest_word;
  logic [2:0]  digest_index;
  logic        digest_last;
  modport source (output valid, digest_word, digest_index, digest_last, input ready);
  modport sink (input valid, digest_word, digest_index, digest_last, output ready);
endinterface
`default_nettype wire

FILE: hw/rtl/sha384_core.sv
// SHA-512 family compression core: one round per cycle over a rolling schedule.
`default_nettype none
module sha384_core import sha384_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire core_ctl_t   ctl_i,
  input  wire logic [63:0] blk_i [BlockWords],
  output core_stat_t       stat_o,
  output logic [63:0]      cv_o [8]
);

  logic [63:0] cv_q [8];
  logic [63:0] wv_q [8];
  logic [63:0] win_q [BlockWords];
  logic [6:0]  rnd_q;
  logic        busy_q, fin_q;

  logic [63:0] w, t1, t2, ch, maj, sg0, sg1;

  always_comb begin
    sg1 = rotr(win_q[14], 19) ^ rotr(win_q[14], 61) ^ (win_q[14] >> 6);
    sg0 = rotr(win_q[1], 1) ^ rotr(win_q[1], 8) ^ (win_q[1] >> 7);
    w   = (rnd_q < 7'(BlockWords)) ? win_q[0] : sg1 + win_q[9] + sg0 + win_q[0];
    ch  = wv_q[6] ^ (wv_q[4] & (wv_q[5] ^ wv_q[6]));
    maj = (wv_q[0] & wv_q[1]) | (wv_q[2] & (wv_q[0] | wv_q[1]));
    t1  = wv_q[7] + (rotr(wv_q[4], 14) ^ rotr(wv_q[4], 18) ^ rotr(wv_q[4], 41))
        + ch + RoundConst[rnd_q] + w;
    t2  = (rotr(wv_q[0], 28) ^ rotr(wv_q[0], 34) ^ rotr(wv_q[0], 39)) + maj;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      fin_q  <= 1'b0;
      rnd_q  <= '0;
      for (int i = 0; i < 8; i++) cv_q[i] <= InitValue[i];
    end else begin
      fin_q <= 1'b0;
      if (ctl_i.init) begin
        for (int i = 0; i < 8; i++) cv_q[i] <= InitValue[i];
      end else if (fin_q) begin
        for (int i = 0; i < 8; i++) cv_q[i] <= cv_q[i] + wv_q[i];
      end
      if (ctl_i.start) begin
        busy_q <= 1'b1;
        rnd_q  <= '0;
      end else if (busy_q) begin
        if (rnd_q == LastRound) begin
          busy_q <= 1'b0;
          fin_q  <= 1'b1;
          rnd_q  <= '0;
        end else begin
          rnd_q <= rnd_q + 7'd1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.start) begin
      for (int i = 0; i < 8; i++) wv_q[i] <= cv_q[i];
      for (int i = 0; i < BlockWords; i++) win_q[i] <= blk_i[i];
    end else if (busy_q) begin
      for (int i = 0; i < BlockWords - 1; i++) win_q[i] <= win_q[i+1];
      win_q[BlockWords-1] <= w;
      wv_q[7] <= wv_q[6];
      wv_q[6] <= wv_q[5];
      wv_q[5] <= wv_q[4];
      wv_q[4] <= wv_q[3] + t1;
      wv_q[3] <= wv_q[2];
      wv_q[2] <= wv_q[1];
      wv_q[1] <= wv_q[0];
      wv_q[0] <= t1 + t2;
    end
  end

  assign stat_o.busy = busy_q;
  assign stat_o.done = fin_q;
  assign cv_o = cv_q;

  a_start_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl_i.start |-> !busy_q && !fin_q) else $error("core started while busy");
  a_rnd_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> rnd_q <= LastRound) else $error("round counter out of range");
  a_fin_after_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (busy_q && rnd_q == LastRound && !ctl_i.start) |=> fin_q)
    else $error("missing chaining update after last round");

endmodule
`default_nettype wire

FILE: hw/rtl/sha384_hash_top.sv
// Top level of the streaming SHA-384 engine: byte packing, padding, digest output.
// Each accepted message word merges into the 128-byte block buffer; each full block
// is then loaded into the core, run through 80 rounds and added into the chaining
// value while input is held off. A final word adds padding steps, up to two blocks,
// then six digest words, one per accepted output handshake. Asynchronous active-low
// reset returns the chaining value to the SHA-384 initial value and clears counts.
`default_nettype none
module sha384_hash_top import sha384_pkg::*; (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  sha384_msg_if.sink   msg_i,
  sha384_dig_if.source dig_o
);

  // One-hot sequencer states.
  typedef enum logic [7:0] {
    ST_IDLE  = 8'b0000_0001,
    ST_PAD80 = 8'b0000_0010,
    ST_PADZ  = 8'b0000_0100,
    ST_LENHI = 8'b0000_1000,
    ST_LENLO = 8'b0001_0000,
    ST_LOAD  = 8'b0010_0000,
    ST_RUN   = 8'b0100_0000,
    ST_OUT   = 8'b1000_0000
  } state_e;

  state_e state_q, state_d, ret_q, ret_d;

  logic [63:0] buf_q [BlockWords];
  logic [6:0]  fill_q;
  logic [63:0] cnt_lo_q, cnt_hi_q;
  logic [63:0] spill_q;
  logic        spill_pend_q;
  logic [2:0]  oidx_q;

  logic        accept, out_take, merge_en;
  logic [3:0]  in_nb, m_nb;
  logic [63:0] m_word, m_new, old_kept, hi_w, lo_w;
  logic [127:0] shifted;
  logic [2:0]  off;
  logic [3:0]  idx;
  logic [7:0]  sum;
  logic        spill, full;
  logic [63:0] bits_hi, bits_lo;
  logic [64:0] lo_sum;

  core_ctl_t   ctl;
  core_stat_t  stat;
  logic [63:0] cv [8];

  assign accept   = msg_i.valid && msg_i.ready;
  assign out_take = dig_o.valid && dig_o.ready;
  assign in_nb    = msg_i.valid_bytes[3] ? 4'd8 : msg_i.valid_bytes;

  // The bit length is the byte count shifted left by three.
  assign bits_hi = {cnt_hi_q[60:0], cnt_lo_q[63:61]};
  assign bits_lo = {cnt_lo_q[60:0], 3'b000};

  // Select what the merge unit packs this cycle.
  always_comb begin
    m_word   = msg_i.message_word;
    m_nb     = in_nb;
    merge_en = 1'b0;
    case (state_q)
      ST_IDLE: begin
        merge_en = accept;
      end
      ST_PAD80: begin
        m_word   = {PadByte, 56'd0};
        m_nb     = 4'd1;
        merge_en = 1'b1;
      end
      ST_PADZ: begin
        m_word   = '0;
        m_nb     = 4'd8 - {1'b0, fill_q[2:0]};
        merge_en = (fill_q != PadStop);
      end
      ST_LENHI: begin
        m_word   = bits_hi;
        m_nb     = 4'd8;
        merge_en = 1'b1;
      end
      ST_LENLO: begin
        m_word   = bits_lo;
        m_nb     = 4'd8;
        merge_en = 1'b1;
      end
      default: begin
        m_nb = 4'd0;
      end
    endcase
  end

  // Merge unit: places m_nb leading bytes at the current byte offset, which
  // may straddle two buffer words.
  always_comb begin
    off = fill_q[2:0];
    idx = fill_q[6:3];
    for (int j = 0; j < 8; j++) begin
      m_new[63-8*j -: 8]    = (4'(j) < m_nb) ? m_word[63-8*j -: 8] : 8'd0;
      old_kept[63-8*j -: 8] = (3'(j) < off) ? buf_q[idx][63-8*j -: 8] : 8'd0;
    end
    shifted = {m_new, 64'd0} >> {off, 3'b000};
    hi_w    = old_kept | shifted[127:64];
    lo_w    = shifted[63:0];
    sum     = {1'b0, fill_q} + {4'd0, m_nb};
    spill   = ({1'b0, off} + m_nb) > 4'd8;
    full    = sum[7];
  end

  always_comb begin
    state_d = state_q;
    ret_d   = ret_q;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          ret_d   = msg_i.last_word ? ST_PAD80 : ST_IDLE;
          state_d = full ? ST_LOAD : ret_d;
        end
      end
      ST_PAD80: begin
        ret_d   = ST_PADZ;
        state_d = full ? ST_LOAD : ST_PADZ;
      end
      ST_PADZ: begin
        if (fill_q == PadStop) begin
          state_d = ST_LENHI;
        end else if (full) begin
          ret_d   = ST_PADZ;
          state_d = ST_LOAD;
        end
      end
      ST_LENHI: begin
        state_d = ST_LENLO;
      end
      ST_LENLO: begin
        ret_d   = ST_OUT;
        state_d = ST_LOAD;
      end
      ST_LOAD: begin
        state_d = ST_RUN;
      end
      ST_RUN: begin
        if (stat.done) state_d = ret_q;
      end
      ST_OUT: begin
        if (out_take && oidx_q == DigestLastIdx) state_d = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  assign lo_sum = {1'b0, cnt_lo_q} + {61'd0, in_nb};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      ret_q        <= ST_IDLE;
      fill_q       <= '0;
      cnt_lo_q     <= '0;
      cnt_hi_q     <= '0;
      spill_pend_q <= 1'b0;
      oidx_q       <= '0;
    end else begin
      state_q <= state_d;
      ret_q   <= ret_d;
      if (merge_en) begin
        fill_q <= sum[6:0];
        if (full) spill_pend_q <= spill;
      end
      if (state_q == ST_LOAD) spill_pend_q <= 1'b0;
      if (accept) begin
        cnt_lo_q <= lo_sum[63:0];
        cnt_hi_q <= cnt_hi_q + {63'd0, lo_sum[64]};
      end
      if (out_take) begin
        if (oidx_q == DigestLastIdx) begin
          oidx_q   <= '0;
          fill_q   <= '0;
          cnt_lo_q <= '0;
          cnt_hi_q <= '0;
        end else begin
          oidx_q <= oidx_q + 3'd1;
        end
      end
    end
  end

  // Block buffer: a spill past the end of a full block waits until the block
  // has been copied into the core, then lands in word zero.
  always_ff @(posedge clk_i) begin
    if (merge_en) begin
      buf_q[idx] <= hi_w;
      if (spill && !full) buf_q[idx + 4'd1] <= lo_w;
      if (full) spill_q <= lo_w;
    end
    if (state_q == ST_LOAD && spill_pend_q) buf_q[0] <= spill_q;
  end

  assign ctl.start = (state_q == ST_LOAD);
  assign ctl.init  = out_take && (oidx_q == DigestLastIdx);

  sha384_core u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctl_i  (ctl),
    .blk_i  (buf_q),
    .stat_o (stat),
    .cv_o   (cv)
  );

  assign msg_i.ready        = (state_q == ST_IDLE);
  assign dig_o.valid        = (state_q == ST_OUT);
  assign dig_o.digest_word  = cv[oidx_q];
  assign dig_o.digest_index = oidx_q;
  assign dig_o.digest_last  = (oidx_q == DigestLastIdx);

  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    dig_o.valid |-> !msg_i.ready) else $error("input open while digest pending");
  a_len_aligned: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_LENHI |-> fill_q == PadStop) else $error("length field misaligned");
  a_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_take && oidx_q == DigestLastIdx) |=> (fill_q == 7'd0 && cnt_lo_q == 64'd0))
    else $error("engine not restarted after digest");
  a_run_core_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_RUN |-> (stat.busy || stat.done)) else $error("core idle during run");

endmodule
`default_nettype wire

FILE: tb/sha384_tb_checker.sv
// Checker for the SHA-384 engine: predicts digests from accepted message words and compares.
`default_nettype none
module sha384_tb_checker import sha384_pkg::*; (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  sha384_msg_if.sink   msg_mon,
  sha384_dig_if.sink   dig_mon,
  output int unsigned  fail_cnt_o,
  output int unsigned  pending_o
);

  typedef struct packed {
    logic [63:0] word;
    logic [2:0]  index;
    logic        last;
  } digest_beat_t;

  logic [63:0]  chain_q [8];
  logic [63:0]  buf_q [16];
  int unsigned  fill_q;
  logic [127:0] len_bytes_q;
  digest_beat_t digest_exp_q [$];

  assign pending_o = digest_exp_q.size();

  // One compression of the block buffer into the chaining value.
  task automatic compress();
    logic [63:0] wv [8];
    logic [63:0] w [16];
    logic [63:0] s0, s1, t1, t2, ch, maj, wt;
    for (int i = 0; i < 8; i++) wv[i] = chain_q[i];
    for (int t = 0; t < 80; t++) begin
      if (t < 16) begin
        wt = buf_q[t];
      end else begin
        s1 = rotr(w[(t-2)&15], 19) ^ rotr(w[(t-2)&15], 61) ^ (w[(t-2)&15] >> 6);
        s0 = rotr(w[(t-15)&15], 1) ^ rotr(w[(t-15)&15], 8) ^ (w[(t-15)&15] >> 7);
        wt = s1 + w[(t-7)&15] + s0 + w[t&15];
      end
      w[t&15] = wt;
      ch  = wv[6] ^ (wv[4] & (wv[5] ^ wv[6]));
      maj = (wv[0] & wv[1]) | (wv[2] & (wv[0] | wv[1]));
      t1 = wv[7] + (rotr(wv[4], 14) ^ rotr(wv[4], 18) ^ rotr(wv[4], 41)) + ch
           + RoundConst[t] + wt;
      t2 = (rotr(wv[0], 28) ^ rotr(wv[0], 34) ^ rotr(wv[0], 39)) + maj;
      wv[7] = wv[6]; wv[6] = wv[5]; wv[5] = wv[4]; wv[4] = wv[3] + t1;
      wv[3] = wv[2]; wv[2] = wv[1]; wv[1] = wv[0]; wv[0] = t1 + t2;
    end
    for (int i = 0; i < 8; i++) chain_q[i] += wv[i];
  endtask

  task automatic add_byte(input logic [7:0] b);
    int unsigned sh;
    sh = (7 - (fill_q % 8)) * 8;
    if (fill_q % 8 == 0) buf_q[fill_q/8] = 64'(b) << sh;
    else buf_q[fill_q/8] |= 64'(b) << sh;
    fill_q++;
    if (fill_q == 128) begin
      compress();
      fill_q = 0;
    end
  endtask

  task automatic restart_hash();
    for (int i = 0; i < 8; i++) chain_q[i] = InitValue[i];
    fill_q = 0;
    len_bytes_q = '0;
  endtask

  task automatic absorb_word(input logic [63:0] data, input logic [3:0] nb_in,
                             input logic last);
    int unsigned nb;
    logic [127:0] bits;
    nb = (nb_in > 8) ? 8 : nb_in;
    for (int i = 0; i < nb; i++) add_byte(data[63-8*i -: 8]);
    len_bytes_q += 128'(nb);
    if (last) begin
      bits = len_bytes_q << 3;
      add_byte(PadByte);
      while (fill_q != PadStop) add_byte(8'h00);
      for (int i = 0; i < 16; i++) add_byte(bits[127-8*i -: 8]);
      for (int i = 0; i < DigestWords; i++)
        digest_exp_q.push_back('{chain_q[i], 3'(i), 1'(i == DigestWords - 1)});
      restart_hash();
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    digest_beat_t e;
    if (!rst_ni) begin
      restart_hash();
      digest_exp_q.delete();
      fail_cnt_o <= 0;
    end else begin
      if (msg_mon.valid && msg_mon.ready)
        absorb_word(msg_mon.message_word, msg_mon.valid_bytes, msg_mon.last_word);
      if (dig_mon.valid && dig_mon.ready) begin
        if (digest_exp_q.size() == 0) begin
          if (fail_cnt_o < 10) $display("unexpected digest word %h", dig_mon.digest_word);
          fail_cnt_o <= fail_cnt_o + 1;
        end else begin
          e = digest_exp_q.pop_front();
          if (e.word !== dig_mon.digest_word || e.index !== dig_mon.digest_index ||
              e.last !== dig_mon.digest_last) begin
            if (fail_cnt_o < 10)
              $display("digest mismatch: exp %h idx %0d last %b, got %h idx %0d last %b",
                       e.word, e.index, e.last, dig_mon.digest_word,
                       dig_mon.digest_index, dig_mon.digest_last);
            fail_cnt_o <= fail_cnt_o + 1;
          end
        end
      end
    end
  end

endmodule
`default_nettype wire

FILE: tb/sha384_hash_top_tb.sv
// Top of the SHA-384 engine testbench: reset, message stimulus, stalls and verdict.
`default_nettype none
module sha384_hash_top_tb;
  import sha384_pkg::*;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  int unsigned fail_cnt, pending, cycle_cnt;

  sha384_msg_if msg_bus ();
  sha384_dig_if dig_bus ();

  sha384_hash_top dut (.clk_i(clk_i), .rst_ni(rst_ni), .msg_i(msg_bus), .dig_o(dig_bus));

  sha384_tb_checker checker_inst (
    .clk_i(clk_i), .rst_ni(rst_ni), .msg_mon(msg_bus), .dig_mon(dig_bus),
    .fail_cnt_o(fail_cnt), .pending_o(pending)
  );

  always #10 clk_i = ~clk_i;

  // Gap length: mostly zero or short, now and then long.
  function automatic int unsigned gap_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  // The receiver stalls at random, with a quiet stretch in the middle of the run.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dig_bus.ready <= 1'b0;
    end else if (cycle_cnt > 20000 && cycle_cnt < 30000) begin
      dig_bus.ready <= 1'b1;
    end else begin
      dig_bus.ready <= ($urandom_range(0, 99) < 65);
    end
  end

  // A generous limit that ends a hung run as failed.
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > 1000000) begin
      $display("sha384_hash_top_tb failed");
      $finish;
    end
  end

  // Drives one word and holds it until the engine takes it.
  task automatic send_word(input logic [63:0] data, input logic [3:0] nb, input logic last);
    int unsigned g;
    g = gap_len();
    // Drop valid only when another word does not follow at once.
    if (g != 0) begin
      msg_bus.valid <= 1'b0;
      repeat (g) @(posedge clk_i);
    end
    msg_bus.valid        <= 1'b1;
    msg_bus.message_word <= data;
    msg_bus.valid_bytes  <= nb;
    msg_bus.last_word    <= last;
    do @(posedge clk_i); while (!msg_bus.ready);
  endtask

  function automatic logic [63:0] rand_word();
    return {$urandom(), $urandom()};
  endfunction

  // A message of full words ending with a final word of random size.
  task automatic send_message(input int unsigned full_words);
    for (int i = 0; i < full_words; i++) send_word(rand_word(), 4'd8, 1'b0);
    send_word(rand_word(), 4'($urandom_range(0, 8)), 1'b1);
  endtask

  initial begin
    int unsigned sent;
    msg_bus.valid = 1'b0;
    msg_bus.message_word = '0;
    msg_bus.valid_bytes = '0;
    msg_bus.last_word = 1'b0;
    cycle_cnt = 0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: the empty message, then extreme patterns and counts.
    send_word(64'h0, 4'd0, 1'b1);
    send_word(64'hFFFF_FFFF_FFFF_FFFF, 4'd8, 1'b1);
    send_word(64'h0, 4'd8, 1'b1);
    // Counts above eight saturate to a full word.
    send_word(64'h0123_4567_89AB_CDEF, 4'd15, 1'b0);
    send_word(64'hFEDC_BA98_7654_3210, 4'd9, 1'b1);
    // Short words in mid-stream continue at byte granularity.
    send_word(64'hAABB_CCDD_EEFF_0011, 4'd3, 1'b0);
    send_word(64'h1122_3344_5566_7788, 4'd5, 1'b0);
    send_word(64'h5555_5555_5555_5555, 4'd1, 1'b0);
    send_word(64'hAAAA_AAAA_AAAA_AAAA, 4'd7, 1'b1);
    // Fourteen full words plus bytes that push padding into a second block.
    send_message(14);

    // The sender holds off until every digest word has come back.
    msg_bus.valid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);

    // Random messages, mostly a few words, sometimes past a block boundary.
    sent = 0;
    while (sent < 270) begin
      int unsigned n, k;
      n = ($urandom_range(0, 9) == 0) ? $urandom_range(14, 34) : $urandom_range(0, 6);
      for (int i = 0; i < n; i++) begin
        k = $urandom_range(0, 9);
        if (k == 0) send_word(rand_word(), 4'($urandom_range(0, 15)), 1'b0);
        else send_word(rand_word(), 4'd8, 1'b0);
      end
      send_word(rand_word(), 4'($urandom_range(0, 15)), 1'b1);
      sent += n + 1;
    end
    msg_bus.valid <= 1'b0;
    @(posedge clk_i);

    while (pending != 0) @(posedge clk_i);
    repeat (200) @(posedge clk_i);
    if (fail_cnt == 0) begin
      $display("sha384_hash_top_tb passed");
    end else begin
      $display("sha384_hash_top_tb failed");
    end
    $finish;
  end

endmodule
`default_nettype wire

FILE: filelist.f
hw/rtl/sha384_pkg.sv
hw/rtl/sha384_if.sv
hw/rtl/sha384_core.sv
hw/rtl/sha384_hash_top.sv
tb/sha384_tb_checker.sv
tb/sha384_hash_top_tb.sv
